[rtl/core/pst_pkg.sv]
// Package for the port scan tracker.
// Holds transfer structs, function codes, state encoding and fixed sizes.
// No dependencies.
package pst_pkg;

    localparam int unsigned LISTEN_BITS  = 32;
    localparam int unsigned LISTEN_ROWS  = 65536 / LISTEN_BITS;
    localparam int unsigned LISTEN_RAW   = 11;

    localparam logic [2:0] FUNC_BEGIN  = 3'd0;
    localparam logic [2:0] FUNC_LISTEN = 3'd1;
    localparam logic [2:0] FUNC_CONN   = 3'd2;
    localparam logic [2:0] FUNC_EXPIRE = 3'd3;
    localparam logic [2:0] FUNC_QUERY  = 3'd4;

    localparam logic CFG_THRESHOLD = 1'b0;
    localparam logic CFG_TTL       = 1'b1;

    localparam logic [4:0]  THRESHOLD_RESET = 5'd8;
    localparam logic [15:0] TTL_RESET       = 16'd300;

    typedef struct packed {
        logic [2:0]  func;
        logic [31:0] now_seconds;
        logic        is_tcp;
        logic        is_listen;
        logic        remote_valid;
        logic [31:0] remote_ip;
        logic [15:0] lport;
    } t_in;

    typedef struct packed {
        logic [4:0] flagged_ports;
        logic [6:0] entry_count;
        logic       dropped;
        logic       counted;
    } t_out;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_LREAD,
        S_LCHECK,
        S_SCAN,
        S_PREP,
        S_PSCAN,
        S_UPDATE,
        S_DONE
    } t_state;

endpackage

[rtl/core/pst_ram.sv]
// Generic simple dual-port RAM: one write port, one registered read port.
// No dependencies.
module pst_ram #(
    parameter int unsigned WIDTH = 8,
    parameter int unsigned DEPTH = 16
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule

[rtl/core/pst_addr_filter.sv]
// Public IPv4 address check for connection records.
// Depends on pst_pkg.
module pst_addr_filter
    import pst_pkg::*;
(
    input  logic [31:0] i_ip,
    output logic        o_public
);
    logic [7:0] a;
    logic [7:0] b;

    always_comb begin
        a = i_ip[31:24];
        b = i_ip[23:16];
        o_public = 1'b1;
        if (a == 8'd0 || a >= 8'd224 || a == 8'd10 || a == 8'd127) o_public = 1'b0;
        if (a == 8'd169 && b == 8'd254) o_public = 1'b0;
        if (a == 8'd172 && b >= 8'd16 && b <= 8'd31) o_public = 1'b0;
        if (a == 8'd192 && b == 8'd168) o_public = 1'b0;
        if (a == 8'd100 && b >= 8'd64 && b <= 8'd127) o_public = 1'b0;
    end
endmodule

[rtl/core/port_scan_tracker.sv]
// Port scan tracker top level: sequencer, listen bitmap, peer table, port lists.
// Depends on pst_pkg, pst_ram and pst_addr_filter.
//
// Input channel: i_in_valid / o_in_stall carry one t_in item per transfer.
// Output channel: o_out_valid / i_out_stall carry one t_out result per item.
// Config channel: i_cfg_valid / o_cfg_ready, index 0 threshold, 1 TTL.
// One item is handled at a time. Steps per function code:
//   begin update: listen bitmap clear over 2048 rows, one row a cycle
//   listen record: listen bitmap read and check, then result
//   connection record: listen check, peer search, duplicate check, update
//   expire, query: peer search over the entry RAM; other codes: result only
// The peer search sweeps the entry RAM one read a cycle; the duplicate
// check sweeps the port list RAM one read a cycle.
// After reset a clearing pass over max(2048, PEER_ENTRIES) addresses runs
// over the listen and entry RAMs; no item is taken meanwhile, config writes still are.
// A finished result waits in the output register while the receiver
// stalls; the next item is accepted, and is held at its end until the
// register frees.
module port_scan_tracker
    import pst_pkg::*;
#(
    parameter int unsigned PEER_ENTRIES   = 64,
    parameter int unsigned PORTS_PER_PEER = 16
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  t_in         i_in_data,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output t_out        o_out_data,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic        i_cfg_index,
    input  logic [15:0] i_cfg_data
);
    localparam int unsigned EAW  = PEER_ENTRIES > 1 ? $clog2(PEER_ENTRIES) : 1;
    localparam int unsigned IW   = $clog2(PEER_ENTRIES + 1);
    localparam int unsigned CW   = $clog2(PORTS_PER_PEER + 1);
    localparam int unsigned PKW  = PORTS_PER_PEER > 1 ? $clog2(PORTS_PER_PEER) : 1;
    localparam int unsigned PDEP = PEER_ENTRIES * PORTS_PER_PEER;
    localparam int unsigned PAW  = PDEP > 1 ? $clog2(PDEP) : 1;
    localparam int unsigned EW   = 1 + 32 + 32 + 1 + CW;
    localparam int unsigned CLRN = LISTEN_ROWS > PEER_ENTRIES ? LISTEN_ROWS : PEER_ENTRIES;
    localparam int unsigned CLRW = $clog2(CLRN + 1);
    localparam int unsigned TW   = CW > 5 ? CW + 1 : 6;

    t_state r_state, n_state;
    t_in    r_item;
    t_out   r_res;
    t_out   r_out;
    logic   r_out_valid;
    logic [IW-1:0]   r_count;
    logic [4:0]      r_thr;
    logic [15:0]     r_ttl;
    logic [31:0]     r_batch;
    logic [CLRW-1:0] r_clr;
    logic            r_clr_ent;
    logic [IW-1:0]   r_rd_idx;
    logic            r_pend;
    logic [EAW-1:0]  r_pend_idx;
    logic            r_hit;
    logic [EAW-1:0]  r_hit_idx;
    logic            r_free_found;
    logic [EAW-1:0]  r_free_idx;
    logic            r_new;
    logic [EAW-1:0]  r_e;
    logic            r_ent_flag;
    logic [CW-1:0]   r_ent_cnt;
    logic [CW-1:0]   r_rd_k;
    logic            r_kpend;
    logic [PKW-1:0]  r_pend_k;
    logic            r_dup;

    logic                   lis_we;
    logic [LISTEN_RAW-1:0]  lis_waddr, lis_raddr;
    logic [LISTEN_BITS-1:0] lis_wdata, lis_rdata;
    logic                   ent_we;
    logic [EAW-1:0]         ent_waddr, ent_raddr;
    logic [EW-1:0]          ent_wdata, ent_rdata;
    logic                   prt_we;
    logic [PAW-1:0]         prt_waddr, prt_raddr, prt_base;
    logic [15:0]            prt_rdata;

    logic        addr_public;
    logic        accept, load, scan_issue, scan_last, k_issue, k_last;
    logic        lis_bit, ev, ef, expired, room;
    logic [31:0] ea, el;
    logic [CW-1:0] ec, new_cnt;

    pst_addr_filter u_filter (
        .i_ip     (i_in_data.remote_ip),
        .o_public (addr_public)
    );

    pst_ram #(.WIDTH(LISTEN_BITS), .DEPTH(LISTEN_ROWS)) u_listen (
        .i_clk(i_clk), .i_we(lis_we), .i_waddr(lis_waddr), .i_wdata(lis_wdata),
        .i_raddr(lis_raddr), .o_rdata(lis_rdata)
    );

    pst_ram #(.WIDTH(EW), .DEPTH(PEER_ENTRIES)) u_entry (
        .i_clk(i_clk), .i_we(ent_we), .i_waddr(ent_waddr), .i_wdata(ent_wdata),
        .i_raddr(ent_raddr), .o_rdata(ent_rdata)
    );

    pst_ram #(.WIDTH(16), .DEPTH(PDEP)) u_ports (
        .i_clk(i_clk), .i_we(prt_we), .i_waddr(prt_waddr), .i_wdata(r_item.lport),
        .i_raddr(prt_raddr), .o_rdata(prt_rdata)
    );

    assign ev = ent_rdata[EW-1];
    assign ea = ent_rdata[EW-2 -: 32];
    assign el = ent_rdata[EW-34 -: 32];
    assign ef = ent_rdata[CW];
    assign ec = ent_rdata[CW-1:0];
    assign expired = !((r_batch - el) < {16'd0, r_ttl});
    assign lis_bit = lis_rdata[r_item.lport[4:0]];

    assign accept     = (r_state == S_IDLE) && i_in_valid;
    assign load       = (r_state == S_DONE) && (!r_out_valid || !i_out_stall);
    assign scan_issue = r_rd_idx < IW'(PEER_ENTRIES);
    assign scan_last  = r_pend && (r_pend_idx == EAW'(PEER_ENTRIES - 1));
    assign k_issue    = r_rd_k < r_ent_cnt;
    assign k_last     = r_kpend && ((CW'(r_pend_k) + CW'(1)) == r_ent_cnt);
    assign room       = r_ent_cnt < CW'(PORTS_PER_PEER);
    assign new_cnt    = r_ent_cnt + CW'(1);
    assign prt_base   = PAW'(r_e) * PAW'(PORTS_PER_PEER);

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_cfg_ready = 1'b1;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: begin
                if (r_clr == CLRW'(CLRN - 1)) n_state = S_DONE;
                if (r_clr_ent && r_clr == CLRW'(CLRN - 1)) n_state = S_IDLE;
            end
            S_IDLE: begin
                if (accept) begin
                    unique case (i_in_data.func)
                        FUNC_BEGIN:  n_state = S_CLEAR;
                        FUNC_LISTEN: n_state = (i_in_data.is_tcp && i_in_data.is_listen)
                                               ? S_LREAD : S_DONE;
                        FUNC_CONN:   n_state = (i_in_data.is_tcp && !i_in_data.is_listen &&
                                                i_in_data.remote_valid && addr_public)
                                               ? S_LREAD : S_DONE;
                        FUNC_EXPIRE: n_state = S_SCAN;
                        FUNC_QUERY:  n_state = S_SCAN;
                        default:     n_state = S_DONE;
                    endcase
                end
            end
            S_LREAD:  n_state = S_LCHECK;
            S_LCHECK: n_state = (r_item.func == FUNC_CONN && lis_bit) ? S_SCAN : S_DONE;
            S_SCAN:   if (scan_last) n_state = (r_item.func == FUNC_CONN) ? S_PREP : S_DONE;
            S_PREP: begin
                if (!r_hit && !r_free_found) n_state = S_DONE;
                else if (r_hit && r_ent_cnt != '0) n_state = S_PSCAN;
                else n_state = S_UPDATE;
            end
            S_PSCAN:  if (k_last) n_state = S_UPDATE;
            S_UPDATE: n_state = S_DONE;
            S_DONE:   if (load) n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
    end

    always_comb begin
        lis_we    = 1'b0;
        lis_waddr = r_item.lport[15:5];
        lis_wdata = lis_rdata | (LISTEN_BITS'(1) << r_item.lport[4:0]);
        lis_raddr = r_item.lport[15:5];
        ent_we    = 1'b0;
        ent_waddr = r_pend_idx;
        ent_wdata = '0;
        ent_raddr = r_rd_idx[EAW-1:0];
        prt_we    = 1'b0;
        prt_waddr = prt_base + PAW'(r_ent_cnt);
        prt_raddr = prt_base + PAW'(r_rd_k);
        unique case (r_state)
            S_CLEAR: begin
                lis_waddr = r_clr[LISTEN_RAW-1:0];
                lis_wdata = '0;
                lis_we    = r_clr < CLRW'(LISTEN_ROWS);
                ent_waddr = r_clr[EAW-1:0];
                ent_we    = r_clr_ent && (r_clr < CLRW'(PEER_ENTRIES));
            end
            S_LCHECK: lis_we = (r_item.func == FUNC_LISTEN);
            S_SCAN: begin
                ent_we = (r_item.func == FUNC_EXPIRE) && r_pend && ev && expired;
            end
            S_UPDATE: begin
                ent_we    = 1'b1;
                ent_waddr = r_e;
                ent_wdata = {1'b1, r_item.remote_ip, r_batch,
                             (!r_dup && room) ? (r_ent_flag || TW'(new_cnt) >= TW'(r_thr))
                                              : r_ent_flag,
                             (!r_dup && room) ? new_cnt : r_ent_cnt};
                prt_we    = !r_dup && room;
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr       <= '0;
            r_clr_ent   <= 1'b1;
            r_count     <= '0;
            r_out_valid <= 1'b0;
            r_thr       <= THRESHOLD_RESET;
            r_ttl       <= TTL_RESET;
            r_batch     <= '0;
            r_pend      <= 1'b0;
            r_kpend     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    CFG_THRESHOLD: r_thr <= i_cfg_data[4:0];
                    CFG_TTL:       r_ttl <= i_cfg_data;
                    default: ;
                endcase
            end
            if (load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + CLRW'(1);
                    if (n_state != S_CLEAR) r_clr_ent <= 1'b0;
                end
                S_IDLE: begin
                    if (accept) begin
                        r_clr        <= '0;
                        r_rd_idx     <= '0;
                        r_pend       <= 1'b0;
                        r_kpend      <= 1'b0;
                        r_rd_k       <= '0;
                        r_hit        <= 1'b0;
                        r_free_found <= 1'b0;
                        r_dup        <= 1'b0;
                        r_new        <= 1'b0;
                        r_ent_cnt    <= '0;
                        r_ent_flag   <= 1'b0;
                        if (i_in_data.func == FUNC_BEGIN) r_batch <= i_in_data.now_seconds;
                    end
                end
                S_SCAN: begin
                    if (scan_issue) r_rd_idx <= r_rd_idx + IW'(1);
                    r_pend     <= scan_issue;
                    r_pend_idx <= r_rd_idx[EAW-1:0];
                    if (r_pend) begin
                        if (ev && ea == r_item.remote_ip && !r_hit) begin
                            r_hit      <= 1'b1;
                            r_hit_idx  <= r_pend_idx;
                            r_ent_flag <= ef;
                            r_ent_cnt  <= ec;
                        end
                        if (!ev && !r_free_found) begin
                            r_free_found <= 1'b1;
                            r_free_idx   <= r_pend_idx;
                        end
                        if (ent_we) r_count <= r_count - IW'(1);
                    end
                end
                S_PREP: begin
                    r_e   <= r_hit ? r_hit_idx : r_free_idx;
                    r_new <= !r_hit;
                end
                S_PSCAN: begin
                    if (k_issue) r_rd_k <= r_rd_k + CW'(1);
                    r_kpend  <= k_issue;
                    r_pend_k <= r_rd_k[PKW-1:0];
                    if (r_kpend && prt_rdata == r_item.lport) r_dup <= 1'b1;
                end
                S_UPDATE: begin
                    if (r_new) r_count <= r_count + IW'(1);
                end
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && accept) begin
            r_res <= '0;
            r_item <= i_in_data;
        end
        if (r_state == S_PREP && !r_hit && !r_free_found) r_res.dropped <= 1'b1;
        if (r_state == S_UPDATE) r_res.counted <= 1'b1;
        if (load) begin
            r_out <= '{flagged_ports: (r_item.func == FUNC_QUERY && r_hit && r_ent_flag)
                                      ? 5'(r_ent_cnt) : 5'd0,
                       entry_count:   7'(r_count),
                       dropped:       r_res.dropped,
                       counted:       r_res.counted};
        end
    end

`ifndef SYNTHESIS
    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= IW'(PEER_ENTRIES))
        else $error("entry count above table size");
    a_out_drain: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && !i_out_stall && !load) |=> !r_out_valid)
        else $error("result not released after transfer");
    a_expire_addr: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (ent_we && r_state == S_SCAN) |-> (r_pend && ent_waddr == r_pend_idx))
        else $error("expire write off the returned entry");
    a_update_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_UPDATE) |=> (r_state == S_DONE))
        else $error("update not followed by result");
`endif
endmodule
